// ===== hw/rtl/etf_pkg.sv =====
package etf_pkg;

  localparam int FRAC_BITS = 28;
  localparam int IMG_SIZE  = 1024;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int COORD_W   = 10;
  localparam int IMG_CMP_W = 13;
  localparam int SQ_W      = PROD_W - 1 - FRAC_BITS;
  localparam int COUNT_W   = 16;
  localparam int COLOR_W   = 24;
  localparam int STEP_W    = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [IMG_CMP_W-1:0] IMG_SIZE_V = IMG_CMP_W'(IMG_SIZE);
  localparam logic [PROD_W-1:0]    FOUR       = PROD_W'(4) << FRAC_BITS;
  localparam logic [8:0]           COLOR_MOD  = 9'd255;

  localparam logic [STEP_W-1:0]         RST_STEP   = STEP_W'(1048576);
  localparam logic signed [WORD_W-1:0]  RST_OFFSET = -WORD_W'(536870912);
  localparam logic [COUNT_W-1:0]        RST_LIMIT  = COUNT_W'(50);
  localparam logic [COLOR_W-1:0]        RST_COLOR  = COLOR_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_STEP,
    REG_OFFSET_RE,
    REG_OFFSET_IM,
    REG_JULIA_RE,
    REG_JULIA_IM,
    REG_LIMIT,
    REG_COLOR
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_MAP_R,
    S_MAP_I,
    S_MAP_END,
    S_SQR_R,
    S_SQR_I,
    S_TEST,
    S_UPD,
    S_COLOR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                       mode;
    logic [STEP_W-1:0]          step;
    logic signed [WORD_W-1:0]   offset_re;
    logic signed [WORD_W-1:0]   offset_im;
    logic signed [WORD_W-1:0]   julia_re;
    logic signed [WORD_W-1:0]   julia_im;
    logic [COUNT_W-1:0]         limit;
    logic [COLOR_W-1:0]         base_color;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
    logic               escaped;
  } result_t;

endpackage

// ===== hw/rtl/etf_mul.sv =====
module etf_mul (
  input  logic                                 clk,
  input  logic signed [etf_pkg::WORD_W-1:0]    a,
  input  logic signed [etf_pkg::WORD_W-1:0]    b,
  output logic signed [etf_pkg::PROD_W-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hw/rtl/etf_core.sv =====
module etf_core (
  input  logic                              clk,
  input  logic                              rst,
  input  etf_pkg::cfg_t                     cfg,
  input  logic                              start,
  input  logic [etf_pkg::COORD_W-1:0]       px,
  input  logic [etf_pkg::COORD_W-1:0]       py,
  output logic                              idle,
  output logic                              res_valid,
  input  logic                              res_ready,
  output etf_pkg::result_t                  res
);

  localparam int W  = etf_pkg::WORD_W;
  localparam int PW = etf_pkg::PROD_W;
  localparam int SW = etf_pkg::SQ_W;
  localparam int CW = etf_pkg::COORD_W;
  localparam int NW = etf_pkg::COUNT_W;

  function automatic logic signed [W-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = PW'({1'b0, {(W-1){1'b1}}});
    lo = -hi - PW'(1);
    if (v > hi) begin
      return hi[W-1:0];
    end else if (v < lo) begin
      return lo[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic logic [7:0] mod255(input logic [NW-1:0] c);
    logic [8:0] s1;
    logic [8:0] s2;
    s1 = 9'(c[15:8]) + 9'(c[7:0]);
    s2 = (s1 >= etf_pkg::COLOR_MOD) ? s1 - etf_pkg::COLOR_MOD : s1;
    return (s2 == etf_pkg::COLOR_MOD) ? 8'd0 : s2[7:0];
  endfunction

  etf_pkg::state_t state, state_next;

  logic [CW-1:0]        x_raw, y_raw, px_m, py_m;
  logic signed [W-1:0]  pre_re, zr, zi, cr, ci;
  logic [SW-1:0]        rr, ii;
  logic [NW-1:0]        count;
  logic                 test_en, esc;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod, shr_sq, shr_ri, sum_map, sum_r, sum_i;
  logic signed [W-1:0]  map_off;
  logic [SW-1:0]        sq_now;
  logic [PW-1:0]        mag;
  logic                 esc_hit, cont, px_big, py_big;
  logic [NW-1:0]        cnt_inc;

  etf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign shr_sq  = prod >>> etf_pkg::FRAC_BITS;
  assign sq_now  = shr_sq[SW-1:0];
  assign shr_ri  = prod >>> (etf_pkg::FRAC_BITS - 1);
  assign map_off = (state == etf_pkg::S_MAP_I) ? cfg.offset_re : cfg.offset_im;
  assign sum_map = prod + PW'(map_off);
  assign sum_r   = PW'(rr) - PW'(ii) + PW'(cr);
  assign sum_i   = shr_ri + PW'(ci);
  assign mag     = PW'(rr) + PW'(sq_now);
  assign esc_hit = test_en && (mag >= etf_pkg::FOUR);
  assign cnt_inc = count + NW'(test_en);
  assign cont    = cnt_inc < cfg.limit;
  assign px_big  = etf_pkg::IMG_CMP_W'(px_m) >= etf_pkg::IMG_SIZE_V;
  assign py_big  = etf_pkg::IMG_CMP_W'(py_m) >= etf_pkg::IMG_SIZE_V;

  assign idle      = (state == etf_pkg::S_IDLE);
  assign res_valid = (state == etf_pkg::S_OUT);
  assign res.x       = x_raw;
  assign res.y       = y_raw;
  assign res.count   = count;
  assign res.escaped = esc;
  assign res.color   = (count == cfg.limit) ? '0 : prod[etf_pkg::COLOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = zr;
    mul_b      = zr;
    unique case (state)
      etf_pkg::S_IDLE: begin
        if (start) begin
          state_next = etf_pkg::S_MOD;
        end
      end
      etf_pkg::S_MOD: begin
        if (!px_big && !py_big) begin
          state_next = etf_pkg::S_MAP_R;
        end
      end
      etf_pkg::S_MAP_R: begin
        mul_a      = W'(px_m);
        mul_b      = W'(cfg.step);
        state_next = etf_pkg::S_MAP_I;
      end
      etf_pkg::S_MAP_I: begin
        mul_a      = W'(py_m);
        mul_b      = W'(cfg.step);
        state_next = etf_pkg::S_MAP_END;
      end
      etf_pkg::S_MAP_END: begin
        state_next = etf_pkg::S_SQR_R;
      end
      etf_pkg::S_SQR_R: begin
        state_next = etf_pkg::S_SQR_I;
      end
      etf_pkg::S_SQR_I: begin
        mul_a      = zi;
        mul_b      = zi;
        state_next = etf_pkg::S_TEST;
      end
      etf_pkg::S_TEST: begin
        mul_a = zr;
        mul_b = zi;
        if (esc_hit || !cont) begin
          state_next = etf_pkg::S_COLOR;
        end else begin
          state_next = etf_pkg::S_UPD;
        end
      end
      etf_pkg::S_UPD: begin
        state_next = etf_pkg::S_SQR_R;
      end
      etf_pkg::S_COLOR: begin
        mul_a      = W'(cfg.base_color);
        mul_b      = W'(mod255(count));
        state_next = etf_pkg::S_OUT;
      end
      etf_pkg::S_OUT: begin
        mul_a = W'(cfg.base_color);
        mul_b = W'(mod255(count));
        if (res_ready) begin
          state_next = etf_pkg::S_IDLE;
        end
      end
      default: state_next = etf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      etf_pkg::S_IDLE: begin
        x_raw   <= px;
        y_raw   <= py;
        px_m    <= px;
        py_m    <= py;
        count   <= NW'(1);
        test_en <= 1'b0;
        esc     <= 1'b0;
      end
      etf_pkg::S_MOD: begin
        if (px_big) begin
          px_m <= px_m - etf_pkg::IMG_SIZE_V[CW-1:0];
        end
        if (py_big) begin
          py_m <= py_m - etf_pkg::IMG_SIZE_V[CW-1:0];
        end
      end
      etf_pkg::S_MAP_I: begin
        pre_re <= sat32(sum_map);
      end
      etf_pkg::S_MAP_END: begin
        if (cfg.mode) begin
          zr <= pre_re;
          zi <= sat32(sum_map);
          cr <= cfg.julia_re;
          ci <= cfg.julia_im;
        end else begin
          zr <= '0;
          zi <= '0;
          cr <= pre_re;
          ci <= sat32(sum_map);
        end
      end
      etf_pkg::S_TEST: begin
        ii <= sq_now;
        if (esc_hit) begin
          esc <= 1'b1;
        end else begin
          count <= cnt_inc;
        end
      end
      etf_pkg::S_SQR_I: begin
        rr <= sq_now;
      end
      etf_pkg::S_UPD: begin
        zr      <= sat32(sum_r);
        zi      <= sat32(sum_i);
        test_en <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/escape_time_fractal_pixel_unit.sv =====
// Each pixel runs iter_count - 1 updates of z = z*z + c, or iter_count updates when it
// escapes. Each update runs two squares and the cross term through the one shared 32x32
// multiplier, the escape compare, then the update of z, and s_tready stays low until the
// result moves to the output register. Synchronous reset loads the register defaults,
// returns the sequencer to idle and clears the output valid.
module escape_time_fractal_pixel_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,   // pixel_x, pixel_y
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [63:0]                     m_tdata,   // out_x, out_y, pixel_color, iter_count
  output logic [0:0]                      m_tuser,   // escaped
  input  logic                            cfg_wr_en,
  input  logic [etf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [etf_pkg::WORD_W-1:0]      cfg_data
);

  etf_pkg::cfg_t    cfg;
  etf_pkg::result_t res;
  logic             core_idle, res_valid, res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= 1'b0;
      cfg.step       <= etf_pkg::RST_STEP;
      cfg.offset_re  <= etf_pkg::RST_OFFSET;
      cfg.offset_im  <= etf_pkg::RST_OFFSET;
      cfg.julia_re   <= '0;
      cfg.julia_im   <= '0;
      cfg.limit      <= etf_pkg::RST_LIMIT;
      cfg.base_color <= etf_pkg::RST_COLOR;
    end else if (cfg_wr_en) begin
      unique case (etf_pkg::reg_idx_t'(cfg_index))
        etf_pkg::REG_MODE:      cfg.mode       <= cfg_data[0];
        etf_pkg::REG_STEP:      cfg.step       <= cfg_data[etf_pkg::STEP_W-1:0];
        etf_pkg::REG_OFFSET_RE: cfg.offset_re  <= cfg_data;
        etf_pkg::REG_OFFSET_IM: cfg.offset_im  <= cfg_data;
        etf_pkg::REG_JULIA_RE:  cfg.julia_re   <= cfg_data;
        etf_pkg::REG_JULIA_IM:  cfg.julia_im   <= cfg_data;
        etf_pkg::REG_LIMIT:     cfg.limit      <= cfg_data[etf_pkg::COUNT_W-1:0];
        etf_pkg::REG_COLOR:     cfg.base_color <= cfg_data[etf_pkg::COLOR_W-1:0];
      endcase
    end
  end

  assign s_tready  = core_idle;
  assign res_ready = !m_tvalid || m_tready;

  etf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (s_tvalid),
    .px        (s_tdata[9:0]),
    .py        (s_tdata[19:10]),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {4'b0, res.count, res.color, res.y, res.x};
      m_tuser <= res.escaped;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a pixel is in flight");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_tvalid)
    else $error("result handoff lost");

  a_escape_below_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[59:44] < cfg.limit)
    else $error("escaped pixel reports a count at the limit");

endmodule
